// ===== design/assert_macros.svh =====
// assertion macros used by the address region table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in a cycle implies a consequence in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in a cycle implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/art_pkg.sv =====
// types and constants of the address region table
package art_pkg;

  localparam int ADDR_W   = 48;
  localparam int PROT_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [ADDR_W-1:0] PAGE_MASK  = 48'h0000_0000_0FFF;
  localparam logic [ADDR_W-1:0] ADDR_TOP   = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] SIZE_LIMIT = ADDR_TOP - PAGE_MASK;
  localparam logic [ADDR_W-1:0] BASE_RESET = 48'h0000_0040_0000;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [PROT_W-1:0] prot;
  } region_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_CHK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_UNM_RD,
    ST_UNM_EV,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_FIN
  } state_t;

endpackage

// ===== design/art_if.sv =====
// request and response channel interfaces
interface art_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [art_pkg::ADDR_W-1:0] addr;
  logic [art_pkg::ADDR_W-1:0] size;
  logic [art_pkg::PROT_W-1:0] prot;
  modport source (output valid, kind, addr, size, prot, input ready);
  modport sink (input valid, kind, addr, size, prot, output ready);
endinterface

interface art_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [art_pkg::STATUS_W-1:0] status;
  logic [art_pkg::ADDR_W-1:0]   result_addr;
  logic [art_pkg::COUNT_W-1:0]  region_count;
  logic [art_pkg::ADDR_W-1:0]   mapped_bytes;
  modport source (output valid, status, result_addr, region_count, mapped_bytes,
                  input ready);
  modport sink (input valid, status, result_addr, region_count, mapped_bytes,
                output ready);
endinterface

// ===== design/art_mem.sv =====
// region store: one write port, one registered read port
module art_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  art_pkg::region_t wdata,
  input  logic [AW-1:0]    raddr,
  output art_pkg::region_t rdata
);

  art_pkg::region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/address_region_table.sv =====
// address region table: sorted region list, first-fit or fixed-address map, exact unmap
// map steps: gap search (address 0 only), check, overlap scan, sorted insert, result;
//   unmap steps: search for the exact region, shift down the entries above it, result
// throughput: one item at a time, next transfer taken the cycle after the result is loaded
// a finished result waits in the output register while the next item is taken
// reset: synchronous, clears region count, mapped total, base register to 0x400000
`include "assert_macros.svh"

module address_region_table #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [art_pkg::ADDR_W-1:0] cfg_data,
  art_req_if.sink                    req,
  art_rsp_if.source                  rsp
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int AW    = art_pkg::ADDR_W;

  art_pkg::state_t state, state_next;

  // item registers and search base register
  logic [AW-1:0]                addr_r;
  logic [AW-1:0]                size_r;
  logic [art_pkg::PROT_W-1:0]   prot_r;
  logic [AW-1:0]                search_base;

  // working registers
  logic [AW-1:0]                cur;
  logic [AW-1:0]                rsize;
  logic [AW-1:0]                end_r;
  logic [CNT_W-1:0]             idx;
  logic [CNT_W-1:0]             pos;
  logic                         pos_found;
  logic [art_pkg::STATUS_W-1:0] status_r;
  logic [AW-1:0]                res_addr;

  // table state
  logic [CNT_W-1:0]             used;
  logic [AW-1:0]                sum;

  // store ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  art_pkg::region_t mem_wdata;
  art_pkg::region_t rd;

  art_mem #(.DEPTH(MAX_REGIONS), .AW(IDX_W)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rd)
  );

  // shared compare unit over the entry just read
  logic          accept;
  logic          more;
  logic          fits;
  logic          ovl;
  logic          before_cur;
  logic          match;
  logic          chk_fail;
  logic          rsp_free;
  logic          next_in_range;
  logic [AW-1:0] cur_al;
  logic [AW-1:0] rsize_w;
  logic [AW-1:0] end_w;

  assign accept        = req.valid && req.ready;
  assign more          = idx < used;
  assign next_in_range = ({1'b0, idx} + (CNT_W + 1)'(1)) < {1'b0, used};
  // gap fits when cur + size <= start without wrap
  assign fits          = (cur <= rd.start_addr) && (size_r <= rd.start_addr - cur);
  assign ovl           = (cur < rd.end_addr) && (end_r > rd.start_addr);
  assign before_cur    = rd.start_addr < cur;
  assign match         = (rd.start_addr == addr_r) &&
                         (rd.end_addr - rd.start_addr == size_r);
  assign cur_al        = cur & ~art_pkg::PAGE_MASK;
  // a size past the limit may wrap here, the limit check below refuses it
  assign rsize_w       = (size_r + art_pkg::PAGE_MASK) & ~art_pkg::PAGE_MASK;
  assign end_w         = cur_al + rsize_w;
  // region would run past the top of the address space
  assign chk_fail      = (size_r > art_pkg::SIZE_LIMIT) ||
                         (rsize_w > art_pkg::ADDR_TOP - cur_al);
  assign rsp_free      = !rsp.valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      art_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.kind == art_pkg::KIND_UNMAP) state_next = art_pkg::ST_UNM_RD;
          else if (req.size == '0)             state_next = art_pkg::ST_FIN;
          else if (req.addr == '0)             state_next = art_pkg::ST_SRCH_RD;
          else                                 state_next = art_pkg::ST_CHK;
        end
      end
      art_pkg::ST_SRCH_RD: state_next = more ? art_pkg::ST_SRCH_EV : art_pkg::ST_CHK;
      art_pkg::ST_SRCH_EV: state_next = fits ? art_pkg::ST_CHK : art_pkg::ST_SRCH_RD;
      art_pkg::ST_CHK:     state_next = chk_fail ? art_pkg::ST_FIN : art_pkg::ST_SCAN_RD;
      art_pkg::ST_SCAN_RD: begin
        if (more)                                   state_next = art_pkg::ST_SCAN_EV;
        else if (32'(used) >= MAX_REGIONS)          state_next = art_pkg::ST_FIN;
        else                                        state_next = art_pkg::ST_INS_RD;
      end
      art_pkg::ST_SCAN_EV: state_next = ovl ? art_pkg::ST_FIN : art_pkg::ST_SCAN_RD;
      art_pkg::ST_INS_RD:  state_next = (idx > pos) ? art_pkg::ST_INS_WR
                                                    : art_pkg::ST_INS_PUT;
      art_pkg::ST_INS_WR:  state_next = art_pkg::ST_INS_RD;
      art_pkg::ST_INS_PUT: state_next = art_pkg::ST_FIN;
      art_pkg::ST_UNM_RD:  state_next = more ? art_pkg::ST_UNM_EV : art_pkg::ST_FIN;
      art_pkg::ST_UNM_EV:  state_next = match ? art_pkg::ST_DEL_RD : art_pkg::ST_UNM_RD;
      art_pkg::ST_DEL_RD:  state_next = next_in_range ? art_pkg::ST_DEL_WR
                                                      : art_pkg::ST_FIN;
      art_pkg::ST_DEL_WR:  state_next = art_pkg::ST_DEL_RD;
      art_pkg::ST_FIN:     state_next = rsp_free ? art_pkg::ST_IDLE : art_pkg::ST_FIN;
      default:             state_next = art_pkg::ST_IDLE;
    endcase
  end

  // store control and input handshake
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx[IDX_W-1:0];
    mem_raddr = idx[IDX_W-1:0];
    mem_wdata = rd;
    unique case (state)
      art_pkg::ST_IDLE:   req.ready = 1'b1;
      // shift up: read entry below, write it one slot higher
      art_pkg::ST_INS_RD: mem_raddr = IDX_W'(idx - CNT_W'(1));
      art_pkg::ST_INS_WR: mem_we = 1'b1;
      art_pkg::ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos[IDX_W-1:0];
        mem_wdata = '{start_addr: cur, end_addr: end_r, prot: prot_r};
      end
      // shift down: read entry above, write it one slot lower
      art_pkg::ST_DEL_RD: mem_raddr = IDX_W'(idx + CNT_W'(1));
      art_pkg::ST_DEL_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= art_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      search_base <= art_pkg::BASE_RESET;
    end else if (cfg_we) begin
      search_base <= cfg_data;
    end
  end

  // table counters
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      sum  <= '0;
    end else begin
      if (state == art_pkg::ST_INS_PUT) begin
        used <= used + CNT_W'(1);
        sum  <= sum + rsize;
      end
      if (state == art_pkg::ST_UNM_EV && match) begin
        sum <= sum - size_r;
      end
      if (state == art_pkg::ST_DEL_RD && !next_in_range) begin
        used <= used - CNT_W'(1);
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      art_pkg::ST_IDLE: begin
        if (accept) begin
          addr_r   <= req.addr;
          size_r   <= req.size;
          prot_r   <= req.prot;
          cur      <= (req.addr == '0) ? search_base : req.addr;
          idx      <= '0;
          res_addr <= '0;
          status_r <= (req.kind == art_pkg::KIND_MAP && req.size == '0)
                      ? art_pkg::STAT_BAD : art_pkg::STAT_OK;
        end
      end
      art_pkg::ST_SRCH_EV: begin
        if (!fits) begin
          cur <= rd.end_addr;
          idx <= idx + CNT_W'(1);
        end
      end
      art_pkg::ST_CHK: begin
        cur       <= cur_al;
        rsize     <= rsize_w;
        end_r     <= end_w;
        idx       <= '0;
        pos       <= used;
        pos_found <= 1'b0;
        if (chk_fail) status_r <= art_pkg::STAT_BAD;
      end
      art_pkg::ST_SCAN_RD: begin
        if (!more && 32'(used) >= MAX_REGIONS) status_r <= art_pkg::STAT_FULL;
      end
      art_pkg::ST_SCAN_EV: begin
        if (ovl) status_r <= art_pkg::STAT_BAD;
        // first entry not below the new start is the insert slot
        if (!pos_found && !before_cur) begin
          pos       <= idx;
          pos_found <= 1'b1;
        end
        idx <= idx + CNT_W'(1);
      end
      art_pkg::ST_INS_WR:  idx <= idx - CNT_W'(1);
      art_pkg::ST_INS_PUT: res_addr <= cur;
      art_pkg::ST_UNM_RD: begin
        if (!more) status_r <= art_pkg::STAT_NOTFOUND;
      end
      art_pkg::ST_UNM_EV: begin
        if (!match) idx <= idx + CNT_W'(1);
      end
      art_pkg::ST_DEL_WR:  idx <= idx + CNT_W'(1);
      default: ;
    endcase
  end

  // output register, loaded once the previous result has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == art_pkg::ST_FIN && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == art_pkg::ST_FIN && rsp_free) begin
      rsp.status       <= status_r;
      rsp.result_addr  <= res_addr;
      rsp.region_count <= art_pkg::COUNT_W'(used);
      rsp.mapped_bytes <= sum;
    end
  end

  `ASSERT_SAME(a_used_max, 1'b1, 32'(used) <= MAX_REGIONS, "region count past capacity")
  `ASSERT_NEXT(a_busy_after_accept, accept, state != art_pkg::ST_IDLE, "idle after transfer")
  `ASSERT_NEXT(a_used_stable_idle, state == art_pkg::ST_IDLE && !accept, used == $past(used), "count moved while idle")

endmodule
